>>> src/msa_pkg.sv
// Shared widths, register codes and saturation helper for the
// max_sum_subarray_at_least_k block. No dependencies.
package msa_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 32;
    localparam int COUNT_W   = 17;
    localparam int WLEN_W    = 9;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int MAX_K_DEF = 256;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = {COUNT_W{1'b1}};

    typedef enum logic [0:0] {
        REG_WINDOW_LEN = 1'b0
    } reg_index_t;

    // Clamp a sum that may have grown by two bits back to the signed SUM_W range.
    function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W+1:0] v);
        logic signed [SUM_W-1:0] res;
        if ((v[SUM_W+1] == v[SUM_W]) && (v[SUM_W] == v[SUM_W-1]))
            res = v[SUM_W-1:0];
        else if (v[SUM_W+1])
            res = {1'b1, {(SUM_W-1){1'b0}}};
        else
            res = {1'b0, {(SUM_W-1){1'b1}}};
        return res;
    endfunction

endpackage

>>> src/msa_in_if.sv
// Sample channel: valid/ready handshake carrying one array element.
// Depends on msa_pkg for field widths.
interface msa_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msa_pkg::SAMPLE_W-1:0]   sample;
    logic                                  last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

>>> src/msa_out_if.sv
// Result channel: valid/ready handshake carrying the best sum and too-short flag.
// Depends on msa_pkg for field widths.
interface msa_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [msa_pkg::SUM_W-1:0]      best_sum;
    logic                                  too_short;

    modport source (output valid, output best_sum, output too_short, input ready);
    modport sink   (input valid, input best_sum, input too_short, output ready);
endinterface

>>> src/max_sum_subarray_at_least_k.sv
// Top level: streaming maximum-sum subarray of at least k elements.
// Depends on msa_pkg, msa_in_if and msa_out_if.
//
//  channel   dir   handshake       payload
//  samples   in    valid/ready     sample[15:0] signed, last_sample
//  results   out   valid/ready     best_sum[31:0] signed, too_short
//  apb       in    psel/penable    window_len at byte address 0 (9 bits)
//
// One sample per cycle while not stalled. A sample reads both rings on its
// accept edge and is worked on from the input register into the state and
// result registers; the result register loads as the last sample leaves
// the work stage. Reset clears all control state at once; the rings need
// no clearing. A stalled result holds the sample stage only when that sample
// is also marked last; the stage waits until the result register frees up.
module max_sum_subarray_at_least_k #(
    parameter int MAX_K = msa_pkg::MAX_K_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    msa_in_if.sink                        samples,
    msa_out_if.source                     results,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [msa_pkg::ADDR_W-1:0]    paddr,
    input  logic [msa_pkg::DATA_W-1:0]    pwdata,
    output logic [msa_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    localparam int SW  = msa_pkg::SAMPLE_W;
    localparam int UW  = msa_pkg::SUM_W;
    localparam int CNW = msa_pkg::COUNT_W;
    localparam int WW  = msa_pkg::WLEN_W;
    localparam int AW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int KW  = $clog2(MAX_K + 1);
    localparam int LW  = ((WW > KW) ? WW : KW) + 1;
    localparam int PW  = ((AW > KW) ? AW : KW) + 1;
    localparam int CW  = ((CNW > KW) ? CNW : KW) + 1;

    // ---------------- configuration ----------------
    logic [WW-1:0] window_len_reg;
    logic          cfg_wr;
    msa_pkg::reg_index_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = msa_pkg::reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_len_reg <= WW'(1);
        else if (cfg_wr && (cfg_idx == msa_pkg::REG_WINDOW_LEN))
            window_len_reg <= pwdata[WW-1:0];
    end

    always_comb
    begin
        unique case (cfg_idx)
            msa_pkg::REG_WINDOW_LEN: prdata = msa_pkg::DATA_W'(window_len_reg);
            default:                 prdata = '0;
        endcase
    end

    // Effective k: zero acts as one, above MAX_K acts as MAX_K.
    logic [LW-1:0] wl_ext;
    logic [KW-1:0] k_eff;

    always_comb
    begin
        wl_ext = LW'(window_len_reg);
        if (wl_ext == '0)
            k_eff = KW'(1);
        else if (wl_ext > LW'(MAX_K))
            k_eff = KW'(MAX_K);
        else
            k_eff = KW'(wl_ext);
    end

    // ---------------- accept side ----------------
    logic          s1_valid_reg;
    logic          s1_last_reg;
    logic signed [SW-1:0] s1_sample_reg;
    logic [AW-1:0] s1_pos_reg;
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] pos_next;
    logic [AW-1:0] raddr;
    logic [PW-1:0] pos_ext;
    logic [PW-1:0] k_pext;
    logic [PW-1:0] raddr_ext;
    logic          in_acc;
    logic          b_go;
    logic          fwd_hit;

    logic          out_valid_reg;
    logic signed [UW-1:0] best_sum_reg;
    logic          too_short_reg;

    assign b_go           = s1_valid_reg && (!out_valid_reg || results.ready || !s1_last_reg);
    assign samples.ready  = !s1_valid_reg || b_go;
    assign in_acc         = samples.valid && samples.ready;

    assign pos_next = (pos_reg == AW'(MAX_K - 1)) ? '0 : AW'(pos_reg + AW'(1));

    always_comb
    begin
        pos_ext = PW'(pos_reg);
        k_pext  = PW'(k_eff);
        if (pos_ext >= k_pext)
            raddr_ext = pos_ext - k_pext;
        else
            raddr_ext = pos_ext + PW'(MAX_K) - k_pext;
        raddr = raddr_ext[AW-1:0];
    end

    // The slot written by the sample in the work stage is read in the same edge
    // when k is one, and may be after a last sample restarts the position; bypass it.
    assign fwd_hit = s1_valid_reg && (raddr == s1_pos_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                pos_reg <= samples.last_sample ? '0 : pos_next;
            if (in_acc)
                s1_valid_reg <= 1'b1;
            else if (b_go)
                s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_sample_reg <= samples.sample;
            s1_last_reg   <= samples.last_sample;
            s1_pos_reg    <= pos_reg;
        end
    end

    // ---------------- rings ----------------
    logic signed [SW-1:0] sample_ring [MAX_K];
    logic signed [UW-1:0] kadane_ring [MAX_K];
    logic signed [SW-1:0] rd_sample_reg;
    logic signed [UW-1:0] rd_kad_reg;
    logic signed [UW-1:0] kad_next;

    always_ff @(posedge clk)
    begin
        if (b_go)
        begin
            sample_ring[s1_pos_reg] <= s1_sample_reg;
            kadane_ring[s1_pos_reg] <= kad_next;
        end
        if (in_acc)
        begin
            if (fwd_hit)
            begin
                rd_sample_reg <= s1_sample_reg;
                rd_kad_reg    <= kad_next;
            end
            else
            begin
                rd_sample_reg <= sample_ring[raddr];
                rd_kad_reg    <= kadane_ring[raddr];
            end
        end
    end

    // ---------------- work stage ----------------
    logic signed [UW-1:0] kad_reg;
    logic signed [UW-1:0] win_reg;
    logic signed [UW-1:0] best_reg;
    logic [CNW-1:0]       count_reg;

    logic signed [UW+1:0] x_ext;
    logic signed [UW+1:0] gone_ext;
    logic signed [UW-1:0] win_next;
    logic signed [UW-1:0] more;
    logic signed [UW-1:0] best_next;
    logic [CW-1:0]        cnt_x;
    logic [CW-1:0]        cnt_inc;
    logic [CW-1:0]        k_x;
    logic                 i_lt_k;
    logic                 short_arr;

    always_comb
    begin
        x_ext    = {{(UW+2-SW){s1_sample_reg[SW-1]}}, s1_sample_reg};
        gone_ext = {{(UW+2-SW){rd_sample_reg[SW-1]}}, rd_sample_reg};
        cnt_x    = CW'(count_reg);
        cnt_inc  = CW'(cnt_x + CW'(1));
        k_x      = CW'(k_eff);
        i_lt_k   = cnt_x < k_x;
        short_arr = cnt_inc < k_x;
        more     = '0;

        if (i_lt_k)
        begin
            win_next  = msa_pkg::sat_sum({{2{win_reg[UW-1]}}, win_reg} + x_ext);
            best_next = (cnt_inc == k_x) ? win_next : best_reg;
        end
        else
        begin
            win_next  = msa_pkg::sat_sum({{2{win_reg[UW-1]}}, win_reg} + x_ext - gone_ext);
            more      = msa_pkg::sat_sum({{2{rd_kad_reg[UW-1]}}, rd_kad_reg}
                                         + {{2{win_next[UW-1]}}, win_next});
            best_next = best_reg;
            if (win_next > best_next)
                best_next = win_next;
            if (more > best_next)
                best_next = more;
        end

        if ((count_reg == '0) || kad_reg[UW-1])
            kad_next = UW'(x_ext);
        else
            kad_next = msa_pkg::sat_sum({{2{kad_reg[UW-1]}}, kad_reg} + x_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kad_reg   <= '0;
            win_reg   <= '0;
            best_reg  <= '0;
            count_reg <= '0;
        end
        else if (b_go)
        begin
            if (s1_last_reg)
            begin
                kad_reg   <= '0;
                win_reg   <= '0;
                best_reg  <= '0;
                count_reg <= '0;
            end
            else
            begin
                kad_reg  <= kad_next;
                win_reg  <= win_next;
                best_reg <= best_next;
                if (count_reg != msa_pkg::COUNT_LIMIT)
                    count_reg <= CNW'(count_reg + CNW'(1));
            end
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (b_go && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (results.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (b_go && s1_last_reg)
        begin
            too_short_reg <= short_arr;
            best_sum_reg  <= short_arr ? '0 : best_next;
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.best_sum  = best_sum_reg;
    assign results.too_short = too_short_reg;

    // ---------------- assertions ----------------
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && results.too_short |-> results.best_sum == '0)
        else $error("too_short result with nonzero sum");

    a_pos_restart: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready && samples.last_sample |=> pos_reg == '0)
        else $error("ring position not restarted after last sample");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg && s1_last_reg))
        else $error("result raised without a last sample in the work stage");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !b_go |-> s1_last_reg && out_valid_reg)
        else $error("work stage stalled without a pending result");

endmodule

>>> tb/msa_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the max_sum_subarray_at_least_k testbench: a bit-true predictor
// of the block plus the queue of array results it still waits for. Depends on msa_pkg.
package msa_tb_pkg;

    localparam longint SUM_HI = (longint'(1) <<< (msa_pkg::SUM_W - 1)) - 1;
    localparam longint SUM_LO = -(longint'(1) <<< (msa_pkg::SUM_W - 1));

    typedef struct packed {
        logic signed [msa_pkg::SUM_W-1:0] best_sum;
        logic                             too_short;
    } array_result_t;

    function automatic int clamp_sum(longint v);
        if (v > SUM_HI)
            return int'(SUM_HI);
        if (v < SUM_LO)
            return int'(SUM_LO);
        return int'(v);
    endfunction

    class best_sum_board;
        int                         kadane_run;
        int                         window_run;
        int                         best_run;
        int unsigned                seen;
        int unsigned                slot;
        shortint                    sample_hist[msa_pkg::MAX_K_DEF];
        int                         kadane_hist[msa_pkg::MAX_K_DEF];
        logic [msa_pkg::WLEN_W-1:0] min_len;
        array_result_t              awaited[$];
        int                         mismatches;

        function new();
            clear_array();
            min_len    = msa_pkg::WLEN_W'(1);
            mismatches = 0;
        endfunction

        function void clear_array();
            kadane_run = 0;
            window_run = 0;
            best_run   = 0;
            seen       = 0;
            slot       = 0;
        endfunction

        function void write_window_len(logic [msa_pkg::WLEN_W-1:0] v);
            min_len = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // One accepted sample request: advance the array state, queue a result on last.
        function void take_sample(logic signed [msa_pkg::SAMPLE_W-1:0] x, logic last);
            longint        xv;
            int unsigned   k;
            int unsigned   i;
            int unsigned   old;
            int            reach;
            array_result_t res;
            xv = longint'(x);
            k  = min_len;
            if (k == 0)
                k = 1;
            if (k > msa_pkg::MAX_K_DEF)
                k = msa_pkg::MAX_K_DEF;
            i = seen;
            if (i < k) begin
                window_run = clamp_sum(longint'(window_run) + xv);
                if (i == k - 1)
                    best_run = window_run;
            end else begin
                // slot of the sample that just left the k-window
                old = (slot + msa_pkg::MAX_K_DEF - k) % msa_pkg::MAX_K_DEF;
                window_run = clamp_sum(longint'(window_run) + xv - longint'(sample_hist[old]));
                if (window_run > best_run)
                    best_run = window_run;
                reach = clamp_sum(longint'(kadane_hist[old]) + longint'(window_run));
                if (reach > best_run)
                    best_run = reach;
            end
            if (i == 0 || kadane_run < 0)
                kadane_run = int'(x);
            else
                kadane_run = clamp_sum(longint'(kadane_run) + xv);
            sample_hist[slot] = x;
            kadane_hist[slot] = kadane_run;
            slot = (slot + 1) % msa_pkg::MAX_K_DEF;
            if (seen < msa_pkg::COUNT_LIMIT)
                seen++;
            if (last) begin
                if (i + 1 < k) begin
                    res.best_sum  = '0;
                    res.too_short = 1'b1;
                end else begin
                    res.best_sum  = best_run;
                    res.too_short = 1'b0;
                end
                awaited.push_back(res);
                clear_array();
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %0d: %s", mismatches, msg);
        endfunction

        function void check_result(logic signed [msa_pkg::SUM_W-1:0] got_sum, logic got_short);
            array_result_t want;
            if (awaited.size() == 0) begin
                flag($sformatf("unexpected result best_sum=%0d too_short=%0b",
                               got_sum, got_short));
                return;
            end
            want = awaited.pop_front();
            if (got_sum !== want.best_sum)
                flag($sformatf("best_sum exp %0d got %0d", want.best_sum, got_sum));
            if (got_short !== want.too_short)
                flag($sformatf("too_short exp %0b got %0b", want.too_short, got_short));
        endfunction

        function void close_out();
            if (awaited.size() != 0)
                flag($sformatf("%0d results never arrived", awaited.size()));
        endfunction
    endclass

endpackage

>>> tb/tb_max_sum_subarray_at_least_k.sv
`timescale 1ns / 1ps
// Top of the max_sum_subarray_at_least_k testbench: clock, reset, APB writes of
// window_len, sample and result handshakes. Depends on msa_pkg, msa_tb_pkg and the RTL.
module tb_max_sum_subarray_at_least_k;

    localparam int SETTLE_CYCLES  = 4;
    localparam int RANDOM_ITEMS   = 1600;
    localparam int END_WAIT_LIMIT = 20000;
    localparam int STALL_CYCLES   = 400;

    localparam logic signed [msa_pkg::SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [msa_pkg::SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [msa_pkg::ADDR_W-1:0] paddr;
    logic [msa_pkg::DATA_W-1:0] pwdata;
    logic [msa_pkg::DATA_W-1:0] prdata;
    logic                       pready;

    msa_in_if  sample_ch ();
    msa_out_if result_ch ();

    msa_tb_pkg::best_sum_board board = new();
    bit            steady;        // no random idling on either side
    int unsigned   stall_left;    // cycles the result side still holds off

    max_sum_subarray_at_least_k uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (sample_ch),
        .results (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < 24);
    endfunction

    function automatic logic signed [msa_pkg::SAMPLE_W-1:0] pick_sample(int flavor);
        logic signed [msa_pkg::SAMPLE_W-1:0] v;
        case (flavor)
            0: v = msa_pkg::SAMPLE_W'($urandom());
            1: v = msa_pkg::SAMPLE_W'(int'($urandom_range(200)) - 100);
            2:
                case ($urandom_range(4))
                    0:       v = SAMPLE_MIN;
                    1:       v = SAMPLE_MAX;
                    2:       v = -16'sd1;
                    3:       v = 16'sd0;
                    default: v = 16'sd1;
                endcase
            default: v = msa_pkg::SAMPLE_W'(int'($urandom_range(40767)) - 8000);
        endcase
        return v;
    endfunction

    task automatic write_reg(input msa_pkg::reg_index_t idx,
                             input logic [msa_pkg::WLEN_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= msa_pkg::ADDR_W'(4 * int'(idx));
        pwdata  <= msa_pkg::DATA_W'(v);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        board.write_window_len(v);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // valid stays up after an accept; the next call either idles or replaces the payload
    task automatic send_sample(input logic signed [msa_pkg::SAMPLE_W-1:0] x, input bit last);
        while (take_break()) begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid       <= 1'b1;
        sample_ch.sample      <= x;
        sample_ch.last_sample <= last;
        do
            @(posedge clk);
        while (!sample_ch.ready);
        board.take_sample(x, last);
    endtask

    task automatic send_array(input int unsigned len, input bit closed);
        int unsigned n;
        int          flavor;
        flavor = $urandom_range(3);
        for (n = 0; n < len; n++)
            send_sample(pick_sample(flavor), closed && (n == len - 1));
    endtask

    // block is idle once every result is back and the last plain sample has settled
    task automatic wait_for_results();
        sample_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side: check accepted results, drive ready
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && result_ch.valid && result_ch.ready)
                board.check_result(result_ch.best_sum, result_ch.too_short);
            if (stall_left != 0) begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= !take_break();
            end
        end
    end

    initial begin
        int unsigned                phase;
        int unsigned                len;
        int unsigned                keff;
        int unsigned                phase_items;
        int unsigned                random_sent;
        int unsigned                guard;
        logic [msa_pkg::WLEN_W-1:0] wlen;

        rst_n                 <= 1'b0;
        psel                  <= 1'b0;
        penable               <= 1'b0;
        pwrite                <= 1'b0;
        paddr                 <= '0;
        pwdata                <= '0;
        sample_ch.valid       <= 1'b0;
        sample_ch.sample      <= '0;
        sample_ch.last_sample <= 1'b0;
        steady                 = 1'b0;
        stall_left             = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on length of one, single-sample arrays at both extremes
        send_sample(SAMPLE_MAX, 1'b1);
        send_sample(SAMPLE_MIN, 1'b1);

        wait_for_results();
        write_reg(msa_pkg::REG_WINDOW_LEN, 9'd3);
        send_sample(16'sd5, 1'b0);
        send_sample(-16'sd1, 1'b1);             // too short
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd4, 1'b0);
        send_sample(16'sd100, 1'b1);

        // zero length acts as one
        wait_for_results();
        write_reg(msa_pkg::REG_WINDOW_LEN, 9'd0);
        send_sample(-16'sd5, 1'b0);
        send_sample(-16'sd7, 1'b1);

        // above the ring depth acts as the ring depth
        wait_for_results();
        write_reg(msa_pkg::REG_WINDOW_LEN, 9'd511);
        send_sample(16'sd1, 1'b0);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sd3, 1'b1);

        // length drops mid-array before the first full window: best sum starts at 0
        wait_for_results();
        write_reg(msa_pkg::REG_WINDOW_LEN, 9'd10);
        send_sample(-16'sd20, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(-16'sd9, 1'b0);
        send_sample(-16'sd1, 1'b0);
        wait_for_results();
        write_reg(msa_pkg::REG_WINDOW_LEN, 9'd2);
        send_sample(-16'sd4, 1'b0);
        send_sample(-16'sd8, 1'b0);
        send_sample(-16'sd2, 1'b0);
        send_sample(-16'sd6, 1'b0);
        send_sample(-16'sd30, 1'b1);

        random_sent = 0;
        phase       = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_for_results();
            case (phase)
                0: wlen = 9'd256;
                1: wlen = 9'd1;
                2: wlen = 9'd0;
                6: wlen = 9'd1;
                default:
                    case ($urandom_range(9)) inside
                        0:       wlen = msa_pkg::WLEN_W'($urandom_range(257, 511));
                        1:       wlen = 9'd256;
                        [2:3]:   wlen = msa_pkg::WLEN_W'($urandom_range(9, 64));
                        default: wlen = msa_pkg::WLEN_W'($urandom_range(1, 8));
                    endcase
            endcase
            write_reg(msa_pkg::REG_WINDOW_LEN, wlen);
            keff   = (wlen == 0) ? 1 : ((wlen > msa_pkg::MAX_K_DEF) ? msa_pkg::MAX_K_DEF : wlen);
            steady = (phase == 3);
            // result side holds off while short arrays keep coming: input must back up
            if (phase == 6)
                stall_left = STALL_CYCLES;
            phase_items = 0;
            while (phase_items < 120 && random_sent < RANDOM_ITEMS) begin
                case ($urandom_range(3))
                    0:       len = $urandom_range(1, keff);
                    1:       len = keff + $urandom_range(0, 2);
                    default: len = keff + $urandom_range(1, 30);
                endcase
                send_array(len, 1'b1);
                phase_items += len;
                random_sent += len;
            end
            // sometimes leave an array open so the next length applies mid-array
            if ($urandom_range(3) == 0) begin
                len = $urandom_range(1, keff + 4);
                send_array(len, 1'b0);
                random_sent += len;
            end
            phase++;
        end
        steady = 1'b0;

        sample_ch.valid <= 1'b0;
        guard = 0;
        while (board.pending() != 0 && guard < END_WAIT_LIMIT) begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.close_out();
        if (board.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
src/msa_pkg.sv
src/msa_in_if.sv
src/msa_out_if.sv
src/max_sum_subarray_at_least_k.sv
tb/msa_tb_pkg.sv
tb/tb_max_sum_subarray_at_least_k.sv
